[hdl/source_map_vlq_mapping_decoder_macros.svh]
// Assertion macros shared by the source map VLQ mapping decoder RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SOURCE_MAP_VLQ_MAPPING_DECODER_MACROS_SVH
`define SOURCE_MAP_VLQ_MAPPING_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMVD_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define SMVD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

[hdl/smvd_pkg.sv]
// Types, codes and the Base64 digit decode for the source map VLQ mapping decoder.
// No dependencies; used by the result queue and the top level.
`default_nettype none

package smvd_pkg;

    localparam int POS_W     = 32;
    localparam int NUM_POS   = 6;
    localparam int NUM_DELTA = 5;

    localparam int POS_GEN_ROW  = 0;
    localparam int POS_GEN_COL  = 1;
    localparam int POS_SRC      = 2;
    localparam int POS_ORIG_ROW = 3;
    localparam int POS_ORIG_COL = 4;
    localparam int POS_NAME     = 5;

    localparam logic [2:0] KIND_RECORD     = 3'd0;
    localparam logic [2:0] KIND_END_OK     = 3'd1;
    localparam logic [2:0] KIND_BAD_CHAR   = 3'd2;
    localparam logic [2:0] KIND_UNFINISHED = 3'd3;
    localparam logic [2:0] KIND_EMPTY_SEG  = 3'd4;
    localparam logic [2:0] HALT_RUN        = 3'd0;

    localparam logic [2:0] FCNT_ONE  = 3'd1;
    localparam logic [2:0] FCNT_FULL = 3'd5;
    localparam logic [2:0] FCNT_MAX  = 3'd7;

    localparam logic [7:0] CHAR_COMMA   = 8'h2C;
    localparam logic [7:0] CHAR_SEMI    = 8'h3B;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;

    localparam logic [6:0] LOWER_BASE    = 7'd26;
    localparam logic [6:0] NUMERAL_BASE  = 7'd52;
    localparam logic [6:0] DIGIT_PLUS    = 7'd62;
    localparam logic [6:0] DIGIT_SLASH   = 7'd63;
    localparam logic [6:0] DIGIT_INVALID = 7'd64;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic [2:0]       kind;
        logic [POS_W-1:0] orig_row;
        logic [POS_W-1:0] orig_col;
        logic [POS_W-1:0] gen_row;
        logic [POS_W-1:0] gen_col;
        logic [POS_W-1:0] source_index;
        logic [POS_W-1:0] name_index;
        logic             last_result;
    } result_t;

    typedef struct packed {
        logic    push_a;
        logic    push_b;
        result_t entry_a;
        result_t entry_b;
    } queue_push_t;

    // Returns the 6-bit digit value, or DIGIT_INVALID for anything else.
    function automatic logic [6:0] digit_value(input logic [7:0] c);
        logic [6:0] d;
        d = DIGIT_INVALID;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            d = 7'(c - CHAR_UPPER_A);
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            d = 7'(c - CHAR_LOWER_A) + LOWER_BASE;
        end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = 7'(c - CHAR_ZERO) + NUMERAL_BASE;
        end else if (c == CHAR_PLUS) begin
            d = DIGIT_PLUS;
        end else if (c == CHAR_SLASH) begin
            d = DIGIT_SLASH;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

[hdl/smvd_result_queue.sv]
// Four-entry result queue that takes up to two results per cycle and gives one.
// Depends on smvd_pkg for the result and push types.
`default_nettype none

module smvd_result_queue (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire smvd_pkg::queue_push_t push,
    input  wire logic                  pop,
    output smvd_pkg::result_t          head,
    output logic                       not_empty,
    output logic                       has_room
);

    smvd_pkg::result_t               mem_reg [smvd_pkg::QUEUE_DEPTH];
    logic [smvd_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [smvd_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [smvd_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic [smvd_pkg::QPTR_W-1:0]     wr_ptr_b;
    logic [smvd_pkg::QCNT_W-1:0]     push_cnt;

    assign wr_ptr_b  = wr_ptr_reg + 1'b1;
    assign push_cnt  = smvd_pkg::QCNT_W'(push.push_a) + smvd_pkg::QCNT_W'(push.push_b);
    assign head      = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign has_room  = (count_reg <= smvd_pkg::QCNT_W'(smvd_pkg::QUEUE_DEPTH - 2));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + smvd_pkg::QPTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + smvd_pkg::QPTR_W'(pop);
        count_next  = count_reg + push_cnt - smvd_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.push_a) begin
            mem_reg[wr_ptr_reg] <= push.entry_a;
        end
        if (push.push_b) begin
            mem_reg[wr_ptr_b] <= push.entry_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[hdl/source_map_vlq_mapping_decoder.sv]
// Top level of the source map mappings decoder: VLQ digit decode, segment close, positions.
// Depends on smvd_pkg, smvd_result_queue and the assertion macro header.
//
//   channel  | ports                                   | carries
//   ---------+-----------------------------------------+-------------------------------
//   s_       | s_valid s_ready s_char_code s_last_char | one mappings character
//   m_       | m_valid m_ready m_kind ... m_last_result| one record or closing status
//
// An item is decoded in the cycle it is accepted and its results enter a four-entry queue.
// One item can be accepted every cycle while the queue has room for two results.
// A final character that closes a segment gives two results, so the queue drains one behind.
// Reset is synchronous and clears the decode state, running positions and the queue.
// A stall on m_ready stops input only once the queue has fewer than two free entries.
`default_nettype none
`include "source_map_vlq_mapping_decoder_macros.svh"

module source_map_vlq_mapping_decoder #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_char_code,
    input  wire logic               s_last_char,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [2:0]              m_kind,
    output logic signed [31:0]      m_orig_row,
    output logic signed [31:0]      m_orig_col,
    output logic signed [31:0]      m_gen_row,
    output logic signed [31:0]      m_gen_col,
    output logic signed [31:0]      m_source_index,
    output logic signed [31:0]      m_name_index,
    output logic                    m_last_result
);

    localparam int SHW = $clog2(VALUE_BITS + 5);
    localparam int PW  = smvd_pkg::POS_W;

    logic [VALUE_BITS-1:0] accum_reg, accum_next;
    logic [SHW-1:0]        shift_reg, shift_next;
    logic                  pending_reg, pending_next;
    logic [2:0]            fcnt_reg, fcnt_next;
    logic                  nonempty_reg, nonempty_next;
    logic [PW-1:0]         deltas_reg [smvd_pkg::NUM_DELTA];
    logic [PW-1:0]         deltas_next [smvd_pkg::NUM_DELTA];
    logic [PW-1:0]         pos_reg [smvd_pkg::NUM_POS];
    logic [PW-1:0]         pos_next [smvd_pkg::NUM_POS];
    logic [2:0]            halt_reg, halt_next;

    logic                    accept;
    logic [6:0]              dval;
    logic                    is_digit, is_comma, is_semi, cont;
    logic                    shift_live;
    logic [VALUE_BITS-1:0]   addend, acc_sum;
    logic [VALUE_BITS+31:0]  mag_wide;
    logic [PW-1:0]           mag, vdec;
    logic [PW-1:0]           dig_deltas [smvd_pkg::NUM_DELTA];
    logic [2:0]              dig_fcnt;
    logic                    cl_pending;
    logic [2:0]              cl_fcnt;
    logic [PW-1:0]           cl_deltas [smvd_pkg::NUM_DELTA];
    logic [2:0]              cl_halt;
    logic                    cl_record;
    logic [PW-1:0]           cl_pos [smvd_pkg::NUM_POS];
    logic                    do_close, rec_push;
    logic [2:0]              halt_final;
    smvd_pkg::result_t       rec_entry, status_entry, head;
    smvd_pkg::queue_push_t   push;
    logic                    has_room, not_empty;

    assign accept     = s_valid && s_ready;
    assign dval       = smvd_pkg::digit_value(s_char_code);
    assign is_digit   = !dval[6];
    assign is_comma   = (s_char_code == smvd_pkg::CHAR_COMMA);
    assign is_semi    = (s_char_code == smvd_pkg::CHAR_SEMI);
    assign cont       = dval[5];
    assign shift_live = (shift_reg < SHW'(VALUE_BITS));
    assign addend     = {{(VALUE_BITS-5){1'b0}}, dval[4:0]} << shift_reg;
    assign acc_sum    = shift_live ? (accum_reg + addend) : accum_reg;
    assign mag_wide   = {32'd0, (acc_sum >> 1)};
    assign mag        = mag_wide[PW-1:0];
    assign vdec       = acc_sum[0] ? (32'd0 - mag) : mag;
    assign dig_fcnt   = cont ? fcnt_reg
                      : ((fcnt_reg < smvd_pkg::FCNT_MAX) ? (fcnt_reg + 3'd1) : fcnt_reg);

    // The segment being closed is either the stored one or the one just finished by a digit.
    always_comb begin
        for (int i = 0; i < smvd_pkg::NUM_DELTA; i++) begin
            dig_deltas[i] = deltas_reg[i];
            if (!cont && fcnt_reg == 3'(i)) begin
                dig_deltas[i] = vdec;
            end
            cl_deltas[i] = is_digit ? dig_deltas[i] : deltas_reg[i];
        end
        cl_pending = is_digit ? cont : pending_reg;
        cl_fcnt    = is_digit ? dig_fcnt : fcnt_reg;
    end

    always_comb begin
        for (int i = 0; i < smvd_pkg::NUM_POS; i++) begin
            cl_pos[i] = pos_reg[i];
        end
        cl_halt   = smvd_pkg::HALT_RUN;
        cl_record = 1'b0;
        if (cl_pending) begin
            cl_halt = smvd_pkg::KIND_UNFINISHED;
        end else if (cl_fcnt == 3'd0) begin
            cl_halt = smvd_pkg::KIND_EMPTY_SEG;
        end else begin
            cl_pos[smvd_pkg::POS_GEN_COL] = pos_reg[smvd_pkg::POS_GEN_COL] + cl_deltas[0];
            if (cl_fcnt != smvd_pkg::FCNT_ONE) begin
                cl_record = 1'b1;
                cl_pos[smvd_pkg::POS_SRC]      = pos_reg[smvd_pkg::POS_SRC] + cl_deltas[1];
                cl_pos[smvd_pkg::POS_ORIG_ROW] = pos_reg[smvd_pkg::POS_ORIG_ROW] + cl_deltas[2];
                cl_pos[smvd_pkg::POS_ORIG_COL] = pos_reg[smvd_pkg::POS_ORIG_COL] + cl_deltas[3];
                if (cl_fcnt == smvd_pkg::FCNT_FULL) begin
                    cl_pos[smvd_pkg::POS_NAME] = pos_reg[smvd_pkg::POS_NAME] + cl_deltas[4];
                end
            end
        end
    end

    always_comb begin
        accum_next    = accum_reg;
        shift_next    = shift_reg;
        pending_next  = pending_reg;
        fcnt_next     = fcnt_reg;
        nonempty_next = nonempty_reg;
        halt_next     = halt_reg;
        for (int i = 0; i < smvd_pkg::NUM_DELTA; i++) begin
            deltas_next[i] = deltas_reg[i];
        end
        for (int i = 0; i < smvd_pkg::NUM_POS; i++) begin
            pos_next[i] = pos_reg[i];
        end
        do_close   = 1'b0;
        rec_push   = 1'b0;
        halt_final = halt_reg;

        if (accept && halt_reg == smvd_pkg::HALT_RUN) begin
            if (is_comma) begin
                do_close = 1'b1;
            end else if (is_semi) begin
                do_close = nonempty_reg;
            end else if (is_digit) begin
                do_close      = s_last_char;
                nonempty_next = 1'b1;
                pending_next  = cont;
                fcnt_next     = dig_fcnt;
                accum_next    = cont ? acc_sum : '0;
                shift_next    = (cont && shift_live) ? (shift_reg + SHW'(5))
                              : (cont ? shift_reg : '0);
                for (int i = 0; i < smvd_pkg::NUM_DELTA; i++) begin
                    deltas_next[i] = dig_deltas[i];
                end
            end else begin
                halt_next = smvd_pkg::KIND_BAD_CHAR;
            end

            if (do_close) begin
                halt_next     = cl_halt;
                rec_push      = cl_record;
                accum_next    = '0;
                shift_next    = '0;
                pending_next  = 1'b0;
                fcnt_next     = '0;
                nonempty_next = 1'b0;
                for (int i = 0; i < smvd_pkg::NUM_DELTA; i++) begin
                    deltas_next[i] = '0;
                end
                for (int i = 0; i < smvd_pkg::NUM_POS; i++) begin
                    pos_next[i] = cl_pos[i];
                end
            end

            if (is_semi && halt_next == smvd_pkg::HALT_RUN) begin
                pos_next[smvd_pkg::POS_GEN_ROW] = pos_reg[smvd_pkg::POS_GEN_ROW] + 32'd1;
                pos_next[smvd_pkg::POS_GEN_COL] = '0;
            end
            halt_final = halt_next;
        end

        // The final character of a text returns every decode register to its reset value.
        if (accept && s_last_char) begin
            accum_next    = '0;
            shift_next    = '0;
            pending_next  = 1'b0;
            fcnt_next     = '0;
            nonempty_next = 1'b0;
            halt_next     = smvd_pkg::HALT_RUN;
            for (int i = 0; i < smvd_pkg::NUM_DELTA; i++) begin
                deltas_next[i] = '0;
            end
            for (int i = 0; i < smvd_pkg::NUM_POS; i++) begin
                pos_next[i] = '0;
            end
        end
    end

    always_comb begin
        rec_entry.kind         = smvd_pkg::KIND_RECORD;
        rec_entry.orig_row     = cl_pos[smvd_pkg::POS_ORIG_ROW];
        rec_entry.orig_col     = cl_pos[smvd_pkg::POS_ORIG_COL];
        rec_entry.gen_row      = cl_pos[smvd_pkg::POS_GEN_ROW];
        rec_entry.gen_col      = cl_pos[smvd_pkg::POS_GEN_COL];
        rec_entry.source_index = cl_pos[smvd_pkg::POS_SRC];
        rec_entry.name_index   = cl_pos[smvd_pkg::POS_NAME];
        rec_entry.last_result  = 1'b0;

        status_entry.kind         = (halt_final == smvd_pkg::HALT_RUN) ? smvd_pkg::KIND_END_OK
                                                                       : halt_final;
        status_entry.orig_row     = '0;
        status_entry.orig_col     = '0;
        status_entry.gen_row      = '0;
        status_entry.gen_col      = '0;
        status_entry.source_index = '0;
        status_entry.name_index   = '0;
        status_entry.last_result  = 1'b1;

        push.push_a  = rec_push || (accept && s_last_char);
        push.push_b  = rec_push && s_last_char;
        push.entry_a = rec_push ? rec_entry : status_entry;
        push.entry_b = status_entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accum_reg    <= '0;
            shift_reg    <= '0;
            pending_reg  <= 1'b0;
            fcnt_reg     <= '0;
            nonempty_reg <= 1'b0;
            halt_reg     <= smvd_pkg::HALT_RUN;
            for (int i = 0; i < smvd_pkg::NUM_DELTA; i++) begin
                deltas_reg[i] <= '0;
            end
            for (int i = 0; i < smvd_pkg::NUM_POS; i++) begin
                pos_reg[i] <= '0;
            end
        end else begin
            accum_reg    <= accum_next;
            shift_reg    <= shift_next;
            pending_reg  <= pending_next;
            fcnt_reg     <= fcnt_next;
            nonempty_reg <= nonempty_next;
            halt_reg     <= halt_next;
            for (int i = 0; i < smvd_pkg::NUM_DELTA; i++) begin
                deltas_reg[i] <= deltas_next[i];
            end
            for (int i = 0; i < smvd_pkg::NUM_POS; i++) begin
                pos_reg[i] <= pos_next[i];
            end
        end
    end

    smvd_result_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .pop       (m_valid && m_ready),
        .head      (head),
        .not_empty (not_empty),
        .has_room  (has_room)
    );

    assign s_ready        = has_room;
    assign m_valid        = not_empty;
    assign m_kind         = head.kind;
    assign m_orig_row     = head.orig_row;
    assign m_orig_col     = head.orig_col;
    assign m_gen_row      = head.gen_row;
    assign m_gen_col      = head.gen_col;
    assign m_source_index = head.source_index;
    assign m_name_index   = head.name_index;
    assign m_last_result  = head.last_result;

    `SMVD_ASSERT_NEXT(a_last_char_resets, aclk, aresetn, accept && s_last_char, (halt_reg == smvd_pkg::HALT_RUN) && (fcnt_reg == 3'd0) && !pending_reg && !nonempty_reg && (pos_reg[smvd_pkg::POS_GEN_ROW] == 32'd0))
    `SMVD_ASSERT_IMPLIES(a_status_has_no_position, aclk, aresetn, m_valid && m_last_result, (m_kind != smvd_pkg::KIND_RECORD) && (m_gen_row == 32'sd0) && (m_gen_col == 32'sd0) && (m_orig_row == 32'sd0))
    `SMVD_ASSERT_IMPLIES(a_halted_item_is_silent, aclk, aresetn, accept && !s_last_char && (halt_reg != smvd_pkg::HALT_RUN), !push.push_a && !push.push_b)

endmodule

`default_nettype wire

[tb/source_map_vlq_mapping_decoder_tb.sv]
// Self-checking testbench for the source map VLQ mapping decoder: directed rows, then random
// mappings text checked against a local decoder model. Depends on smvd_pkg and the RTL top.
`default_nettype none

module source_map_vlq_mapping_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_BITS     = 32;
    localparam int ITEM_TARGET    = 2000;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_RESULTS   = 150;
    localparam int HOLD_CYCLES    = 150;
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_REPORTS    = 40;
    localparam int NUM_DIRECTED   = 24;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       typed;
        logic [2:0] status;
    } directed_row_t;

    // Rows with typed set carry the closing status kind written in by hand.
    localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{8'hFF,                1'b1, 1'b1, smvd_pkg::KIND_BAD_CHAR},
        '{8'h00,                1'b0, 1'b0, smvd_pkg::KIND_RECORD},
        '{"A",                  1'b1, 1'b1, smvd_pkg::KIND_BAD_CHAR},
        '{smvd_pkg::CHAR_COMMA, 1'b1, 1'b1, smvd_pkg::KIND_EMPTY_SEG},
        '{"g",                  1'b0, 1'b0, smvd_pkg::KIND_RECORD},
        '{smvd_pkg::CHAR_COMMA, 1'b1, 1'b1, smvd_pkg::KIND_UNFINISHED},
        '{smvd_pkg::CHAR_SEMI,  1'b0, 1'b0, smvd_pkg::KIND_RECORD},
        '{"C",                  1'b0, 1'b0, smvd_pkg::KIND_RECORD},
        '{smvd_pkg::CHAR_COMMA, 1'b0, 1'b0, smvd_pkg::KIND_RECORD},
        '{"A",                  1'b0, 1'b0, smvd_pkg::KIND_RECORD},
        '{"C",                  1'b0, 1'b0, smvd_pkg::KIND_RECORD},
        '{"E",                  1'b0, 1'b0, smvd_pkg::KIND_RECORD},
        '{"G",                  1'b0, 1'b0, smvd_pkg::KIND_RECORD},
        '{"F",                  1'b0, 1'b0, smvd_pkg::KIND_RECORD},
        '{smvd_pkg::CHAR_COMMA, 1'b0, 1'b0, smvd_pkg::KIND_RECORD},
        '{smvd_pkg::CHAR_PLUS,  1'b0, 1'b0, smvd_pkg::KIND_RECORD},
        '{smvd_pkg::CHAR_SLASH, 1'b0, 1'b0, smvd_pkg::KIND_RECORD},
        '{smvd_pkg::CHAR_SLASH, 1'b0, 1'b0, smvd_pkg::KIND_RECORD},
        '{smvd_pkg::CHAR_SLASH, 1'b0, 1'b0, smvd_pkg::KIND_RECORD},
        '{smvd_pkg::CHAR_SLASH, 1'b0, 1'b0, smvd_pkg::KIND_RECORD},
        '{smvd_pkg::CHAR_SLASH, 1'b0, 1'b0, smvd_pkg::KIND_RECORD},
        '{smvd_pkg::CHAR_SLASH, 1'b0, 1'b0, smvd_pkg::KIND_RECORD},
        '{"f",                  1'b0, 1'b0, smvd_pkg::KIND_RECORD},
        '{"A",                  1'b1, 1'b0, smvd_pkg::KIND_RECORD}
    };

    logic               aclk;
    logic               aresetn        = 1'b0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic [7:0]         s_char_code    = 8'h00;
    logic               s_last_char    = 1'b0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic [2:0]         m_kind;
    logic signed [31:0] m_orig_row;
    logic signed [31:0] m_orig_col;
    logic signed [31:0] m_gen_row;
    logic signed [31:0] m_gen_col;
    logic signed [31:0] m_source_index;
    logic signed [31:0] m_name_index;
    logic               m_last_result;

    // Local decoder state.
    logic [VALUE_BITS-1:0] vlq_sum;
    logic [5:0]            vlq_bitpos;
    logic                  vlq_open;
    logic [2:0]            fields_seen;
    logic                  seg_started;
    logic [31:0]           seg_deltas [smvd_pkg::NUM_DELTA];
    logic [31:0]           positions [smvd_pkg::NUM_POS];
    logic [2:0]            halt_code;
    smvd_pkg::result_t     mapping_queue [$];

    logic [7:0] text_chars [$];
    int         error_count    = 0;
    int         live_chars     = 0;
    int         chars_sent     = 0;
    int         records_seen   = 0;
    int         statuses_seen  = 0;
    int         texts_sent     = 0;
    int         idle_cycles    = 0;

    source_map_vlq_mapping_decoder #(
        .VALUE_BITS(VALUE_BITS)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_code   (s_char_code),
        .s_last_char   (s_last_char),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_orig_row    (m_orig_row),
        .m_orig_col    (m_orig_col),
        .m_gen_row     (m_gen_row),
        .m_gen_col     (m_gen_col),
        .m_source_index(m_source_index),
        .m_name_index  (m_name_index),
        .m_last_result (m_last_result)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_REPORTS) begin
            $display("%0t ns: %s", $realtime, msg);
        end
        error_count++;
    endtask

    function automatic void clear_segment_state();
        vlq_sum     = '0;
        vlq_bitpos  = '0;
        vlq_open    = 1'b0;
        fields_seen = '0;
        seg_started = 1'b0;
        foreach (seg_deltas[i]) begin
            seg_deltas[i] = '0;
        end
    endfunction

    function automatic void clear_decoder_state();
        clear_segment_state();
        foreach (positions[i]) begin
            positions[i] = '0;
        end
        halt_code = smvd_pkg::HALT_RUN;
    endfunction

    function automatic void push_mapping(input logic [2:0] kind, input logic with_pos,
                                         input logic last);
        smvd_pkg::result_t r;
        r.kind         = kind;
        r.orig_row     = with_pos ? positions[smvd_pkg::POS_ORIG_ROW] : '0;
        r.orig_col     = with_pos ? positions[smvd_pkg::POS_ORIG_COL] : '0;
        r.gen_row      = with_pos ? positions[smvd_pkg::POS_GEN_ROW] : '0;
        r.gen_col      = with_pos ? positions[smvd_pkg::POS_GEN_COL] : '0;
        r.source_index = with_pos ? positions[smvd_pkg::POS_SRC] : '0;
        r.name_index   = with_pos ? positions[smvd_pkg::POS_NAME] : '0;
        r.last_result  = last;
        mapping_queue.insert(mapping_queue.size(), r);
    endfunction

    function automatic void add_text_char(input logic [7:0] c);
        text_chars.insert(text_chars.size(), c);
    endfunction

    function automatic logic [6:0] base64_code(input logic [7:0] c);
        if (c >= "A" && c <= "Z") begin
            return 7'(c - "A");
        end else if (c >= "a" && c <= "z") begin
            return 7'(c - "a") + 7'd26;
        end else if (c >= "0" && c <= "9") begin
            return 7'(c - "0") + 7'd52;
        end else if (c == smvd_pkg::CHAR_PLUS) begin
            return smvd_pkg::DIGIT_PLUS;
        end else if (c == smvd_pkg::CHAR_SLASH) begin
            return smvd_pkg::DIGIT_SLASH;
        end
        return smvd_pkg::DIGIT_INVALID;
    endfunction

    function automatic void take_digit(input logic [5:0] d);
        logic [31:0] mag;
        logic [31:0] delta;
        if (vlq_bitpos < VALUE_BITS) begin
            vlq_sum = vlq_sum + (VALUE_BITS'(d[4:0]) << vlq_bitpos);
        end
        seg_started = 1'b1;
        if (d[5]) begin
            vlq_open = 1'b1;
            if (vlq_bitpos < VALUE_BITS) begin
                vlq_bitpos = vlq_bitpos + 6'd5;
            end
        end else begin
            mag   = 32'(vlq_sum >> 1);
            delta = vlq_sum[0] ? -mag : mag;
            if (fields_seen < smvd_pkg::FCNT_FULL) begin
                seg_deltas[fields_seen] = delta;
            end
            if (fields_seen < smvd_pkg::FCNT_MAX) begin
                fields_seen++;
            end
            vlq_sum    = '0;
            vlq_bitpos = '0;
            vlq_open   = 1'b0;
        end
    endfunction

    function automatic void close_segment();
        if (vlq_open) begin
            halt_code = smvd_pkg::KIND_UNFINISHED;
        end else if (fields_seen == 3'd0) begin
            halt_code = smvd_pkg::KIND_EMPTY_SEG;
        end else if (fields_seen == smvd_pkg::FCNT_ONE) begin
            positions[smvd_pkg::POS_GEN_COL] += seg_deltas[0];
        end else begin
            positions[smvd_pkg::POS_GEN_COL]  += seg_deltas[0];
            positions[smvd_pkg::POS_SRC]      += seg_deltas[1];
            positions[smvd_pkg::POS_ORIG_ROW] += seg_deltas[2];
            positions[smvd_pkg::POS_ORIG_COL] += seg_deltas[3];
            if (fields_seen == smvd_pkg::FCNT_FULL) begin
                positions[smvd_pkg::POS_NAME] += seg_deltas[4];
            end
            push_mapping(smvd_pkg::KIND_RECORD, 1'b1, 1'b0);
            records_seen++;
        end
        clear_segment_state();
    endfunction

    // Decodes one accepted character and queues the results that it causes.
    function automatic void decode_mapping_char(input logic [7:0] c, input logic last,
                                                input logic typed, input logic [2:0] status);
        logic [6:0] d;
        if (halt_code == smvd_pkg::HALT_RUN) begin
            live_chars++;
            if (c == smvd_pkg::CHAR_COMMA) begin
                close_segment();
            end else if (c == smvd_pkg::CHAR_SEMI) begin
                if (seg_started) begin
                    close_segment();
                end
                if (halt_code == smvd_pkg::HALT_RUN) begin
                    positions[smvd_pkg::POS_GEN_ROW]++;
                    positions[smvd_pkg::POS_GEN_COL] = '0;
                end
            end else begin
                d = base64_code(c);
                if (d == smvd_pkg::DIGIT_INVALID) begin
                    halt_code = smvd_pkg::KIND_BAD_CHAR;
                end else begin
                    take_digit(d[5:0]);
                end
            end
            if (last && halt_code == smvd_pkg::HALT_RUN && seg_started) begin
                close_segment();
            end
        end
        if (last) begin
            if (typed) begin
                push_mapping(status, 1'b0, 1'b1);
            end else begin
                push_mapping(halt_code == smvd_pkg::HALT_RUN ? smvd_pkg::KIND_END_OK
                                                              : halt_code, 1'b0, 1'b1);
            end
            statuses_seen++;
            clear_decoder_state();
        end
    endfunction

    function automatic logic [7:0] encode_digit(input int v);
        if (v < 26) begin
            return 8'("A" + v);
        end else if (v < 52) begin
            return 8'("a" + v - 26);
        end else if (v < 62) begin
            return 8'("0" + v - 52);
        end else if (v == 62) begin
            return smvd_pkg::CHAR_PLUS;
        end
        return smvd_pkg::CHAR_SLASH;
    endfunction

    function automatic void append_number();
        int roll;
        int ndig;
        roll = $urandom_range(0, 99);
        ndig = (roll < 60) ? 1 : (roll < 85) ? 2 : (roll < 95) ? $urandom_range(3, 5) :
               $urandom_range(6, 8);
        for (int i = 0; i < ndig - 1; i++) begin
            add_text_char(encode_digit(32 + $urandom_range(0, 31)));
        end
        add_text_char(encode_digit($urandom_range(0, 31)));
    endfunction

    function automatic void build_wellformed_text();
        int nlines;
        int nseg;
        int nfield;
        int roll;
        nlines = $urandom_range(1, 3);
        for (int l = 0; l < nlines; l++) begin
            if (l > 0) begin
                add_text_char(smvd_pkg::CHAR_SEMI);
            end
            nseg = $urandom_range(0, 4);
            for (int s = 0; s < nseg; s++) begin
                if (s > 0) begin
                    add_text_char(smvd_pkg::CHAR_COMMA);
                end
                roll   = $urandom_range(0, 99);
                nfield = (roll < 15) ? 1 : (roll < 25) ? $urandom_range(2, 3) :
                         (roll < 55) ? 4 : (roll < 90) ? 5 : $urandom_range(6, 7);
                for (int f = 0; f < nfield; f++) begin
                    append_number();
                end
            end
        end
        if ($urandom_range(0, 4) == 0 || text_chars.size() == 0) begin
            add_text_char(smvd_pkg::CHAR_SEMI);
        end
    endfunction

    // Mostly well-formed text; some is broken on purpose and some is plain noise.
    function automatic void build_text();
        int roll;
        int pos;
        text_chars.delete();
        roll = $urandom_range(0, 99);
        if (roll < 80) begin
            build_wellformed_text();
        end else if (roll < 90) begin
            build_wellformed_text();
            pos = $urandom_range(0, text_chars.size() - 1);
            case ($urandom_range(0, 2))
                0: begin
                    text_chars[pos] = 8'($urandom_range(0, 255));
                end
                1: begin
                    text_chars.insert(pos, smvd_pkg::CHAR_COMMA);
                    text_chars.insert(pos, smvd_pkg::CHAR_COMMA);
                end
                default: begin
                    add_text_char(encode_digit(32 + $urandom_range(0, 31)));
                end
            endcase
        end else begin
            repeat ($urandom_range(1, 10)) begin
                add_text_char(8'($urandom_range(0, 255)));
            end
        end
    endfunction

    int send_stretch = 0;
    bit send_calm    = 1'b0;

    task automatic send_char(input logic [7:0] c, input logic last, input logic typed,
                             input logic [2:0] status);
        int gap;
        if (send_stretch == 0) begin
            send_stretch = $urandom_range(10, 60);
            send_calm    = ($urandom_range(0, 3) == 0);
        end
        send_stretch--;
        gap = send_calm ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_char_code <= c;
        s_last_char <= last;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        chars_sent++;
        decode_mapping_char(c, last, typed, status);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s mismatch: got %0h, expected %0h", name, got, want));
        end
    endtask

    int  recv_stretch   = 0;
    bit  recv_calm      = 1'b0;
    int  results_taken  = 0;
    bit  hold_done      = 1'b0;

    initial begin
        int                stall;
        smvd_pkg::result_t want;
        while (!aresetn) begin
            @(posedge aclk);
        end
        forever begin
            if (!hold_done && results_taken >= HOLD_RESULTS) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (recv_stretch == 0) begin
                    recv_stretch = $urandom_range(10, 60);
                    recv_calm    = ($urandom_range(0, 3) == 0);
                end
                recv_stretch--;
                stall = recv_calm ? 0 : $urandom_range(0, 7);
                if (stall != 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) begin
                @(posedge aclk);
            end
            results_taken++;
            if (mapping_queue.size() == 0) begin
                report_mismatch($sformatf("unexpected result of kind %0d", m_kind));
            end else begin
                want = mapping_queue.pop_front();
                check_field("kind", 32'(m_kind), 32'(want.kind));
                check_field("orig_row", m_orig_row, want.orig_row);
                check_field("orig_col", m_orig_col, want.orig_col);
                check_field("gen_row", m_gen_row, want.gen_row);
                check_field("gen_col", m_gen_col, want.gen_col);
                check_field("source_index", m_source_index, want.source_index);
                check_field("name_index", m_name_index, want.name_index);
                check_field("last_result", 32'(m_last_result), 32'(want.last_result));
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("source_map_vlq_mapping_decoder_tb: errors");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        clear_decoder_state();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            send_char(DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].typed,
                      DIRECTED_ROWS[i].status);
        end
        while (chars_sent < ITEM_TARGET) begin
            build_text();
            for (int i = 0; i < text_chars.size(); i++) begin
                send_char(text_chars[i], i == text_chars.size() - 1, 1'b0,
                          smvd_pkg::KIND_RECORD);
            end
            texts_sent++;
        end
        s_valid <= 1'b0;
        while (mapping_queue.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d characters in %0d texts, %0d of them decoded before any halt.",
                 chars_sent, texts_sent, live_chars);
        $display("They gave %0d records and %0d statuses; mismatches found: %0d.",
                 records_seen, statuses_seen, error_count);
        if (error_count == 0) begin
            $display("source_map_vlq_mapping_decoder_tb: clean");
        end else begin
            $display("source_map_vlq_mapping_decoder_tb: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
